@@ sv/stl_pkg.sv @@
// Package for the sensor table scaling lookup block.
// Holds table sizing, entry layout, status codes and the scaler request type.
package stl_pkg;

  localparam int TABLE_DEPTH   = 64;
  localparam int FRACTION_BITS = 8;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W    = 16;
  localparam int RAW_W   = 16;
  localparam int RANGE_W = 16;
  localparam int RES_W   = 5;
  localparam int STAT_W  = 3;
  localparam int VALUE_W = 24;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [RANGE_W-1:0] rmin;
    logic signed [RANGE_W-1:0] rmax;
    logic [RES_W-1:0]          res;
    logic                      act;
  } stl_entry_t;

  localparam int ENTRY_W = $bits(stl_entry_t);

  typedef struct packed {
    logic                      start;
    logic [RAW_W-1:0]          raw;
    logic signed [RANGE_W-1:0] rmin;
    logic signed [RANGE_W-1:0] rmax;
    logic [RES_W-1:0]          res;
  } stl_scl_req_t;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STAT_W-1:0] ST_INACTIVE = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] ST_STORED   = 3'd5;

  localparam logic OP_APPEND  = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

endpackage

@@ sv/stl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module stl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/stl_scale.sv @@
// Three-stage linear scaler: multiply, floor shift plus offset, saturate.
// Depends on stl_pkg.
module stl_scale
  import stl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  stl_scl_req_t              req,
  output logic                      done,
  output logic signed [VALUE_W-1:0] value
);

  localparam int PROD_W = 2 * (RANGE_W + 1);
  localparam int TERM_W = PROD_W + FRACTION_BITS;
  localparam int SUM_W  = TERM_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (VALUE_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) <<< (VALUE_W - 1));

  logic                      v1_r, v2_r, v3_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [RANGE_W-1:0] rmin1_r;
  logic [RES_W-1:0]          res1_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [VALUE_W-1:0] value_r;

  logic signed [RANGE_W:0]   span;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [TERM_W-1:0]  term;
  logic signed [TERM_W-1:0]  part;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic signed [VALUE_W-1:0] value_nxt;

  always_comb begin
    span     = (RANGE_W + 1)'(req.rmax) - (RANGE_W + 1)'(req.rmin);
    prod_nxt = $signed({1'b0, req.raw}) * span;
    term     = TERM_W'(prod_r) <<< FRACTION_BITS;
    part     = term >>> res1_r;
    sum_nxt  = (SUM_W'(rmin1_r) <<< FRACTION_BITS) + SUM_W'(part);
    if (sum_r > SAT_HI) begin
      value_nxt = VALUE_W'(SAT_HI);
    end else if (sum_r < SAT_LO) begin
      value_nxt = VALUE_W'(SAT_LO);
    end else begin
      value_nxt = VALUE_W'(sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    prod_r  <= prod_nxt;
    rmin1_r <= req.rmin;
    res1_r  <= req.res;
    sum_r   <= sum_nxt;
    value_r <= value_nxt;
  end

  assign done  = v3_r;
  assign value = value_r;

endmodule

@@ sv/sensor_table_scaling_lookup_top.sv @@
// Top level of the sensor table scaling lookup block.
// Depends on stl_pkg, stl_ram and stl_scale.
//
// Usage:
// - Input channel (in_*): one transaction is an append (operation 0) or a
//   convert (operation 1). Accepted when in_valid is high and in_stall low.
// - Result channel (out_*): exactly one transaction per input, in order.
// - Appends store a definition at the next free table slot; a full table
//   returns status table full. An append's result passes through the wait state.
// - A convert scans entries 0 to N-1 of the definition RAM, one per cycle
//   through the single read port, where N is the number of stored entries;
//   an empty table skips the scan. For an active id that is found it then
//   runs the three-stage scaler; an absent or inactive id skips the scaler.
//   One transaction is in work at a time; the next input is taken in the
//   cycle its predecessor's result first shows.
// - The result register lets a new input be taken while a result waits;
//   a stalled result holds, and a finished next result waits behind it.
// - Reset clears the entry count and all control state; the table RAM is
//   not cleared and only entries below the count are ever used.
module sensor_table_scaling_lookup_top
  import stl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic [ID_W-1:0]           in_sensor_id,
  input  logic [RAW_W-1:0]          in_raw_value,
  input  logic signed [RANGE_W-1:0] in_range_min,
  input  logic signed [RANGE_W-1:0] in_range_max,
  input  logic [RES_W-1:0]          in_resolution_bits,
  input  logic                      in_active,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STAT_W-1:0]         out_status,
  output logic signed [VALUE_W-1:0] out_scaled_value
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CHECK = 5'b00100,
    S_SCALE = 5'b01000,
    S_WAIT  = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [1:0]                hits_r, hits_nxt;
  logic [ID_W-1:0]           id_r, id_nxt;
  logic [RAW_W-1:0]          raw_r, raw_nxt;
  stl_entry_t                hit_r, hit_nxt;
  logic [STAT_W-1:0]         pend_status_r, pend_status_nxt;
  logic signed [VALUE_W-1:0] pend_value_r, pend_value_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]         out_status_r, out_status_nxt;
  logic signed [VALUE_W-1:0] out_value_r, out_value_nxt;

  logic                      accept;
  logic                      wr_en;
  stl_entry_t                wr_entry;
  stl_entry_t                rd_entry;
  logic [IDX_W-1:0]          rd_addr;
  stl_scl_req_t              scl_req;
  logic                      scl_done;
  logic signed [VALUE_W-1:0] scl_value;
  logic                      out_free;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign wr_entry.id   = in_sensor_id;
  assign wr_entry.rmin = in_range_min;
  assign wr_entry.rmax = in_range_max;
  assign wr_entry.res  = in_resolution_bits;
  assign wr_entry.act  = in_active;
  assign wr_en = accept && (in_operation == OP_APPEND) && (count_r != CNT_W'(TABLE_DEPTH));
  assign rd_addr = (state_r == S_SCAN) ? idx_r + IDX_W'(1) : '0;

  stl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  assign scl_req.start = (state_r == S_CHECK) && (hits_r != 2'd0) && hit_r.act;
  assign scl_req.raw   = raw_r;
  assign scl_req.rmin  = hit_r.rmin;
  assign scl_req.rmax  = hit_r.rmax;
  assign scl_req.res   = hit_r.res;

  stl_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (scl_req),
    .done  (scl_done),
    .value (scl_value)
  );

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    hits_nxt        = hits_r;
    id_nxt          = id_r;
    raw_nxt         = raw_r;
    hit_nxt         = hit_r;
    pend_status_nxt = pend_status_r;
    pend_value_nxt  = pend_value_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_value_nxt   = out_value_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          id_nxt         = in_sensor_id;
          raw_nxt        = in_raw_value;
          hits_nxt       = 2'd0;
          idx_nxt        = '0;
          pend_value_nxt = '0;
          if (in_operation == OP_APPEND) begin
            state_nxt = S_WAIT;
            if (wr_en) begin
              count_nxt       = count_r + CNT_W'(1);
              pend_status_nxt = ST_STORED;
            end else begin
              pend_status_nxt = ST_FULL;
            end
          end else if (count_r == '0) begin
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_entry.id == id_r) begin
          hit_nxt  = rd_entry;
          hits_nxt = (hits_r == 2'd2) ? 2'd2 : hits_r + 2'd1;
        end
        if ({1'b0, idx_r} == CNT_W'(count_r - CNT_W'(1))) begin
          state_nxt = S_CHECK;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_CHECK: begin
        if (hits_r == 2'd0) begin
          pend_status_nxt = ST_NOTFOUND;
          state_nxt       = S_WAIT;
        end else if (!hit_r.act) begin
          pend_status_nxt = ST_INACTIVE;
          state_nxt       = S_WAIT;
        end else begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (scl_done) begin
          pend_value_nxt  = scl_value;
          pend_status_nxt = (hits_r == 2'd1) ? ST_OK : ST_DUP;
          state_nxt       = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_value_nxt  = pend_value_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r         <= idx_nxt;
    hits_r        <= hits_nxt;
    id_r          <= id_nxt;
    raw_r         <= raw_nxt;
    hit_r         <= hit_nxt;
    pend_status_r <= pend_status_nxt;
    pend_value_r  <= pend_value_nxt;
    out_status_r  <= out_status_nxt;
    out_value_r   <= out_value_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_scaled_value = out_value_r;

endmodule
